FILE: src/rlbs_pkg.sv
package rlbs_pkg;

  // Field widths fixed by the item and register formats
  localparam int LEVEL_W   = 5;
  localparam int COLOUR_W  = 3 * LEVEL_W;
  localparam int TIME_W    = 16;
  localparam int ELAPSED_W = 10;
  localparam int SLOT_W    = 3;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TIME     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_PERIOD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TIME  = 3'd7;

  // Reset values of the timing registers
  localparam logic [TIME_W-1:0] ON_TIME_RST     = 16'd100;
  localparam logic [TIME_W-1:0] SLOT_PERIOD_RST = 16'd300;
  localparam logic [TIME_W-1:0] PAUSE_TIME_RST  = 16'd1000;
  localparam logic [TIME_W-1:0] TIME_MAX        = 16'hFFFF;

  typedef struct packed {
    logic                 seq_update;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } in_t;

  typedef struct packed {
    logic red_on;
    logic green_on;
    logic blue_on;
  } out_t;

  // Sequencer timing settings shared by the register file and the sequencer
  typedef struct packed {
    logic [SLOT_W-1:0] slot_count;
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] slot_period;
    logic [TIME_W-1:0] pause_time;
  } seq_cfg_t;

endpackage

FILE: src/rlbs_cfg.sv
module rlbs_cfg
  import rlbs_pkg::*;
#(
  parameter int SLOTS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [TIME_W-1:0]    wr_data,
  output logic [COLOUR_W-1:0]  colour [SLOTS],
  output seq_cfg_t             seq_cfg
);

  // Colour slots: only the slots the sequencer can reach are stored
  always_ff @(posedge clk) begin
    for (int s = 0; s < SLOTS; s++) begin
      if (rst) begin
        colour[s] <= '0;
      end else if (wr_en && wr_index == (REG_COLOUR_A + CFG_IDX_W'(s))) begin
        colour[s] <= wr_data[COLOUR_W-1:0];
      end
    end
  end

  // Slot count and timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_cfg.slot_count  <= '0;
      seq_cfg.on_time     <= ON_TIME_RST;
      seq_cfg.slot_period <= SLOT_PERIOD_RST;
      seq_cfg.pause_time  <= PAUSE_TIME_RST;
    end else if (wr_en) begin
      if (wr_index == REG_SLOT_COUNT)  seq_cfg.slot_count  <= wr_data[SLOT_W-1:0];
      if (wr_index == REG_ON_TIME)     seq_cfg.on_time     <= wr_data;
      if (wr_index == REG_SLOT_PERIOD) seq_cfg.slot_period <= wr_data;
      if (wr_index == REG_PAUSE_TIME)  seq_cfg.pause_time  <= wr_data;
    end
  end

endmodule

FILE: src/rlbs_seq.sv
module rlbs_seq
  import rlbs_pkg::*;
#(
  parameter int CHANNELS = 3,
  parameter int SLOTS    = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  in_t                  item,
  input  seq_cfg_t             seq_cfg,
  input  logic [COLOUR_W-1:0]  colour [SLOTS],
  output logic [LEVEL_W-1:0]   level_now [CHANNELS]
);

  logic [SLOT_W-1:0]  slot_index, slot_index_next;
  logic               in_pause, in_pause_next;
  logic [TIME_W-1:0]  elapsed_count, elapsed_count_next;
  logic [LEVEL_W-1:0] channel_level [CHANNELS];

  logic [SLOT_W-1:0]   active_slots;
  logic [COLOUR_W-1:0] colour_sel;
  logic [TIME_W-1:0]   count_base;
  logic [TIME_W:0]     count_sum;
  logic                showing;

  // Slot count clamped to the slots that exist
  assign active_slots = (seq_cfg.slot_count > SLOT_W'(SLOTS)) ? SLOT_W'(SLOTS)
                                                                : seq_cfg.slot_count;
  assign showing = !in_pause && (slot_index < active_slots);

  // Colour of the current slot
  always_comb begin
    colour_sel = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_index == SLOT_W'(s)) colour_sel = colour[s];
    end
  end

  // One sequencer step; levels seen by this tick's PWM come out directly
  always_comb begin
    slot_index_next = slot_index;
    in_pause_next   = in_pause;
    count_base      = elapsed_count;
    for (int c = 0; c < CHANNELS; c++) level_now[c] = channel_level[c];

    if (item.seq_update) begin
      if (showing) begin
        for (int c = 0; c < CHANNELS; c++) begin
          level_now[c] = (elapsed_count < seq_cfg.on_time)
                         ? colour_sel[LEVEL_W*(2-c) +: LEVEL_W] : '0;
        end
        if (elapsed_count > seq_cfg.slot_period) begin
          count_base      = '0;
          slot_index_next = slot_index + 1'b1;
        end
      end else begin
        in_pause_next = 1'b1;
        if (elapsed_count > seq_cfg.pause_time) begin
          count_base      = '0;
          slot_index_next = '0;
          in_pause_next   = 1'b0;
        end
      end
      if (slot_index_next >= active_slots) in_pause_next = 1'b1;
    end
  end

  // Saturating add of the elapsed time
  assign count_sum = {1'b0, count_base} + (TIME_W+1)'(item.elapsed_ms);
  assign elapsed_count_next = !item.seq_update ? elapsed_count
                            : count_sum[TIME_W] ? TIME_MAX : count_sum[TIME_W-1:0];

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index    <= '0;
      in_pause      <= 1'b0;
      elapsed_count <= '0;
      for (int c = 0; c < CHANNELS; c++) channel_level[c] <= '0;
    end else if (advance) begin
      slot_index    <= slot_index_next;
      in_pause      <= in_pause_next;
      elapsed_count <= elapsed_count_next;
      for (int c = 0; c < CHANNELS; c++) channel_level[c] <= level_now[c];
    end
  end

endmodule

FILE: src/rlbs_pwm.sv
module rlbs_pwm
  import rlbs_pkg::*;
#(
  parameter int CHANNELS = 3,
  parameter int PWM_TOP  = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [LEVEL_W-1:0] level [CHANNELS],
  output out_t               drive
);

  localparam int PHASE_W = $clog2(PWM_TOP + 1);

  logic [PHASE_W-1:0] pwm_phase [CHANNELS];
  logic [2:0]         lit;

  // Channel is lit while its phase is below its level
  always_comb begin
    lit = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      lit[2-c] = LEVEL_W'(pwm_phase[c]) < level[c];
    end
  end

  assign drive.red_on   = lit[2];
  assign drive.green_on = lit[1];
  assign drive.blue_on  = lit[0];

  // Phase counters wrap after PWM_TOP
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (rst) begin
        pwm_phase[c] <= '0;
      end else if (advance) begin
        pwm_phase[c] <= (pwm_phase[c] == PHASE_W'(PWM_TOP)) ? '0 : pwm_phase[c] + 1'b1;
      end
    end
  end

endmodule

FILE: src/rgb_led_blink_sequencer_pwm_top.sv
// Channel  Handshake              Payload
// in       in_valid / in_stall    in_data   (seq_update, elapsed_ms)
// out      out_valid / out_stall  out_data  (red_on, green_on, blue_on)
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One tick per cycle sustained while out is not stalled; a tick passes through the input
// register, then the result register, and its result shows on out from there.
// The sequencer and PWM state update as a tick moves from the input register
// into the result register. Reset is synchronous and resets all state and registers
// except the in_q and out_data payloads. A stall on out holds the result register
// and backs up into in_stall only once the input register is also full.
module rgb_led_blink_sequencer_pwm_top
  import rlbs_pkg::*;
#(
  parameter int CHANNELS = 3,
  parameter int SLOTS    = 4,
  parameter int PWM_TOP  = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  logic                in_q_valid;
  in_t                 in_q;
  logic                out_open;
  logic                advance;
  logic                in_take;
  logic [COLOUR_W-1:0] colour [SLOTS];
  seq_cfg_t            seq_cfg;
  logic [LEVEL_W-1:0]  level_now [CHANNELS];
  out_t                drive;

  assign cfg_ready = 1'b1;

  // Pipeline flow control
  assign out_open = !out_valid || !out_stall;
  assign advance  = in_q_valid && out_open;
  assign in_stall = in_q_valid && !out_open;
  assign in_take  = in_valid && !in_stall;

  rlbs_cfg #(.SLOTS(SLOTS)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .colour   (colour),
    .seq_cfg  (seq_cfg)
  );

  rlbs_seq #(.CHANNELS(CHANNELS), .SLOTS(SLOTS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (in_q),
    .seq_cfg   (seq_cfg),
    .colour    (colour),
    .level_now (level_now)
  );

  rlbs_pwm #(.CHANNELS(CHANNELS), .PWM_TOP(PWM_TOP)) u_pwm (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .level   (level_now),
    .drive   (drive)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_q <= in_data;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data <= drive;
  end

endmodule

FILE: tb/sv/rgb_led_blink_sequencer_pwm_top_tb.sv
`timescale 1ns / 1ps

module rgb_led_blink_sequencer_pwm_top_tb;
  import rlbs_pkg::*;

  localparam int CHANNELS        = 3;
  localparam int SLOTS           = 4;
  localparam int PWM_TOP         = 20;
  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 6;
  localparam int DRAIN_CYCLES    = 6;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int RANDOM_PHASES   = 6;
  localparam int CALM_PHASE      = 5;
  localparam int IDLE_PCT        = 18;
  localparam int MAX_REPORTS     = 10;
  localparam int RESET_ROWS      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_B = REG_COLOUR_A + 1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_C = REG_COLOUR_A + 2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_D = REG_COLOUR_A + 3;

  typedef struct packed {
    logic typed;
    out_t want;
    in_t  item;
  } tick_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data  = '0;

  // Shadow of the register file
  logic [COLOUR_W-1:0] slot_colour [4];
  logic [SLOT_W-1:0]   shown_slots;
  logic [TIME_W-1:0]   lit_time;
  logic [TIME_W-1:0]   advance_time;
  logic [TIME_W-1:0]   rest_time;

  // Shadow of the sequencer and PWM state
  logic [SLOT_W-1:0]   cur_slot;
  logic                resting;
  logic [TIME_W-1:0]   elapsed_acc;
  logic [LEVEL_W-1:0]  level [3];
  logic [LEVEL_W-1:0]  phase [3];

  out_t      led_expect_q [$];
  tick_row_t script [$];
  bit        calm = 1'b0;
  int        quiet_cycles = 0;
  int        mismatches = 0;
  int        ticks_sent = 0;
  int        results_seen = 0;
  int        reg_writes = 0;

  rgb_led_blink_sequencer_pwm_top #(
    .CHANNELS(CHANNELS),
    .SLOTS   (SLOTS),
    .PWM_TOP (PWM_TOP)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Register and state values right after reset
  task automatic reset_shadow();
    for (int s = 0; s < 4; s++) slot_colour[s] = '0;
    shown_slots  = '0;
    lit_time     = ON_TIME_RST;
    advance_time = SLOT_PERIOD_RST;
    rest_time    = PAUSE_TIME_RST;
    cur_slot     = '0;
    resting      = 1'b0;
    elapsed_acc  = '0;
    for (int c = 0; c < 3; c++) begin
      level[c] = '0;
      phase[c] = '0;
    end
  endtask

  // One tick: optional sequencer step, then PWM on every channel
  function automatic out_t led_tick(in_t it);
    int unsigned         active;
    int unsigned         sum;
    int unsigned         nxt;
    logic [COLOUR_W-1:0] col;
    logic [2:0]          lit;
    out_t                res;
    active = (shown_slots > SLOTS) ? SLOTS : shown_slots;
    if (it.seq_update) begin
      if (!resting && cur_slot < active) begin
        col = slot_colour[cur_slot[1:0]];
        for (int c = 0; c < 3; c++)
          level[c] = (elapsed_acc < lit_time) ? col[LEVEL_W*(2-c) +: LEVEL_W] : '0;
        if (elapsed_acc > advance_time) begin
          elapsed_acc = '0;
          cur_slot    = cur_slot + 1'b1;
        end
      end else begin
        // pause: levels hold their last values
        resting = 1'b1;
        if (elapsed_acc > rest_time) begin
          elapsed_acc = '0;
          cur_slot    = '0;
          resting     = 1'b0;
        end
      end
      if (cur_slot >= active) resting = 1'b1;
      // elapsed count saturates
      sum = elapsed_acc + it.elapsed_ms;
      elapsed_acc = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
    end
    for (int c = 0; c < 3; c++) begin
      if (c < CHANNELS) begin
        lit[c] = (phase[c] < level[c]);
        nxt = phase[c] + 1;
        if (nxt > PWM_TOP) nxt = 0;
        phase[c] = nxt[LEVEL_W-1:0];
      end else begin
        lit[c] = 1'b0;
      end
    end
    res.red_on   = lit[0];
    res.green_on = lit[1];
    res.blue_on  = lit[2];
    return res;
  endfunction

  function automatic void add_row(logic upd, int ms, logic typed, out_t want);
    tick_row_t row;
    row.item.seq_update = upd;
    row.item.elapsed_ms = ms[ELAPSED_W-1:0];
    row.typed = typed;
    row.want  = want;
    script.push_back(row);
  endfunction

  // Drive one tick, hold it until the transfer, then maybe leave idle cycles
  task automatic send_tick(in_t it, logic typed, out_t want);
    out_t predicted;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = led_tick(it);
    led_expect_q.push_back(typed ? want : predicted);
    ticks_sent++;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Wait until every result is back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (led_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unique case (idx)
      REG_SLOT_COUNT:  shown_slots  = val[SLOT_W-1:0];
      REG_ON_TIME:     lit_time     = val;
      REG_SLOT_PERIOD: advance_time = val;
      REG_PAUSE_TIME:  rest_time    = val;
      default:         slot_colour[idx[1:0]] = val[COLOUR_W-1:0];
    endcase
    reg_writes++;
  endtask

  task automatic program_regs(logic [TIME_W-1:0] ca, logic [TIME_W-1:0] cb,
                              logic [TIME_W-1:0] cc, logic [TIME_W-1:0] cd,
                              logic [TIME_W-1:0] cnt, logic [TIME_W-1:0] on_t,
                              logic [TIME_W-1:0] per_t, logic [TIME_W-1:0] pau_t);
    write_reg(REG_COLOUR_A, ca);
    write_reg(REG_COLOUR_B, cb);
    write_reg(REG_COLOUR_C, cc);
    write_reg(REG_COLOUR_D, cd);
    write_reg(REG_SLOT_COUNT, cnt);
    write_reg(REG_ON_TIME, on_t);
    write_reg(REG_SLOT_PERIOD, per_t);
    write_reg(REG_PAUSE_TIME, pau_t);
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_result(out_t want, out_t got, bit orphan);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      if (orphan)
        $display("unexpected LED result r%0b g%0b b%0b", got.red_on, got.green_on,
                 got.blue_on);
      else
        $display("LED mismatch #%0d: expected r%0b g%0b b%0b, got r%0b g%0b b%0b",
                 results_seen, want.red_on, want.green_on, want.blue_on,
                 got.red_on, got.green_on, got.blue_on);
    end
  endtask

  // Result checker and receiver stall
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (led_expect_q.size() == 0) begin
        flag_result('0, out_data, 1'b1);
      end else begin
        want = led_expect_q.pop_front();
        if (out_data.red_on !== want.red_on || out_data.green_on !== want.green_on ||
            out_data.blue_on !== want.blue_on)
          flag_result(want, out_data, 1'b0);
      end
      results_seen++;
    end
    out_stall <= (rst || calm) ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: too long without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("rgb_led_blink_sequencer_pwm_top test failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    in_t it;
    reset_shadow();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: no slots, levels zero, every channel dark
    add_row(1'b0, 0, 1'b1, '0);
    add_row(1'b1, 0, 1'b1, '0);
    add_row(1'b1, 1023, 1'b1, '0);
    add_row(1'b0, 1023, 1'b1, '0);
    add_row(1'b1, 512, 1'b1, '0);
    add_row(1'b1, 1023, 1'b1, '0);
    // short timings, slot count above the slot limit, full and odd colours
    add_row(1'b1, 0, 1'b0, '0);
    add_row(1'b1, 1, 1'b0, '0);
    add_row(1'b1, 1, 1'b0, '0);
    add_row(1'b1, 1, 1'b0, '0);
    add_row(1'b1, 2, 1'b0, '0);
    add_row(1'b1, 1, 1'b0, '0);
    add_row(1'b0, 0, 1'b0, '0);
    add_row(1'b1, 3, 1'b0, '0);
    add_row(1'b1, 1, 1'b0, '0);
    add_row(1'b1, 2, 1'b0, '0);
    add_row(1'b1, 5, 1'b0, '0);
    add_row(1'b1, 1, 1'b0, '0);
    add_row(1'b1, 7, 1'b0, '0);
    add_row(1'b1, 0, 1'b0, '0);
    add_row(1'b1, 1023, 1'b0, '0);
    add_row(1'b1, 1, 1'b0, '0);
    add_row(1'b0, 1023, 1'b0, '0);
    add_row(1'b1, 4, 1'b0, '0);

    foreach (script[i]) begin
      if (i == RESET_ROWS) begin
        settle();
        program_regs(16'h7FFF, 16'h5294, 16'h0421, 16'h7C1F, 16'd5, 16'd3, 16'd4, 16'd6);
      end
      send_tick(script[i].item, script[i].typed, script[i].want);
    end

    // Random phases, each under its own settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      calm = (ph == CALM_PHASE);
      unique case (ph)
        0: program_regs(16'($urandom()), 16'($urandom()), 16'($urandom()),
                        16'($urandom()), 16'd1, 16'd0, 16'd0, 16'd0);
        1: program_regs(16'($urandom()), 16'($urandom()), 16'($urandom()),
                        16'($urandom()), 16'd4, 16'd20, 16'd40, 16'd80);
        2: program_regs(16'($urandom()), 16'($urandom()), 16'($urandom()),
                        16'($urandom()), 16'd7, 16'($urandom_range(30)),
                        16'($urandom_range(50)), 16'($urandom_range(90)));
        3: program_regs(16'hFFFF, 16'($urandom()), 16'($urandom()),
                        16'($urandom()), 16'd4, TIME_MAX, TIME_MAX, TIME_MAX);
        4: program_regs(16'($urandom()), 16'($urandom()), 16'($urandom()),
                        16'($urandom()), 16'($urandom()), 16'($urandom()),
                        16'($urandom()), 16'($urandom()));
        default: program_regs(16'($urandom()), 16'($urandom()), 16'($urandom()),
                              16'($urandom()), 16'd2, 16'($urandom_range(20, 1)),
                              16'($urandom_range(30, 5)), 16'($urandom_range(40)));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it.seq_update = ($urandom_range(99) < 90);
        // mostly short steps so every slot and the pause get visited
        if (ph == 3 || ph == 4 || $urandom_range(99) < 10)
          it.elapsed_ms = ELAPSED_W'($urandom_range(1023));
        else
          it.elapsed_ms = ELAPSED_W'($urandom_range(12));
        send_tick(it, 1'b0, '0);
      end
    end

    settle();
    calm = 1'b0;
    mismatches += led_expect_q.size();
    $display("covered %0d ticks and %0d LED results over %0d register writes",
             ticks_sent, results_seen, reg_writes);
    $display("settings: reset, short timings, zero timings, saturation, random, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("rgb_led_blink_sequencer_pwm_top test passed");
    end else begin
      $display("rgb_led_blink_sequencer_pwm_top test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rlbs_pkg.sv
src/rlbs_cfg.sv
src/rlbs_seq.sv
src/rlbs_pwm.sv
src/rgb_led_blink_sequencer_pwm_top.sv
tb/sv/rgb_led_blink_sequencer_pwm_top_tb.sv
